// ----- sv/ple_pkg.sv -----
// Shared types, codes and default sizes for the positional list engine.
package ple_pkg;

    // Field widths of the request and response transactions.
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Default sizes of the entry store.
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_INS_FIRST = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_LAST  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FIRST = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_LAST  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ_AT   = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

endpackage

// ----- sv/positional_list_engine.sv -----
// Ordered list of up to DEPTH words kept in one RAM, entries moved to insert or delete.
// An accepted request walks the entries it moves or reads with one RAM read each, writes
// the new value for an insert, then loads the response; errors and the unused code load
// it directly. A stalled earlier response delays the load. req_stall holds off a new
// request until the response is loaded. Reset clears the state, count, walk flags and
// response valid; the payload registers are not reset.
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  ple_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output ple_pkg::rsp_t rsp
);

    import ple_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOVE = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] M_INS = 2'd0;
    localparam logic [1:0] M_DEL = 2'd1;
    localparam logic [1:0] M_GET = 2'd2;

    // Control state.
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg, pend_next;
    logic          issued_reg, issued_next;
    logic          first_reg, first_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // Working registers of the current transaction.
    logic [1:0]            mode_reg, mode_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [VALUE_W-1:0]    rv_reg, rv_next;
    rsp_t                  rsp_reg, rsp_next;

    // RAM ports.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Decode of an incoming transaction.
    logic [PW-1:0]       c_ext, p_ext, p_m1, acc_idx;
    logic [STATUS_W-1:0] acc_status;
    logic [1:0]          acc_mode;
    logic                acc_move;
    logic [CW-1:0]       acc_count, acc_rem;
    logic [AW-1:0]       acc_ptr;
    logic [VALUE_W-1:0]  rd_word;

    ple_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ptr_reg),
        .rd_data (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Stored word sign-extended to the response width.
    assign rd_word = VALUE_W'(EXT_W'($signed(ram_rdata)));

    assign c_ext = PW'(count_reg);
    assign p_ext = PW'(req.position);
    assign p_m1  = p_ext - PW'(1);

    // Classify the request against the current count.
    always_comb
    begin
        acc_status = ST_OK;
        acc_mode   = M_GET;
        acc_move   = 1'b0;
        acc_count  = count_reg;
        acc_idx    = '0;
        acc_rem    = '0;
        acc_ptr    = '0;
        unique case (req.func)
            FN_INS_FIRST, FN_INS_LAST, FN_INS_AT:
            begin
                if (c_ext == PW'(DEPTH))
                begin
                    acc_status = ST_FULL;
                end
                else if ((req.func == FN_INS_AT) &&
                         ((p_ext == '0) || (p_ext > c_ext + PW'(1))))
                begin
                    acc_status = ST_RANGE;
                end
                else
                begin
                    if (req.func == FN_INS_FIRST)
                    begin
                        acc_idx = '0;
                    end
                    else if (req.func == FN_INS_LAST)
                    begin
                        acc_idx = c_ext;
                    end
                    else
                    begin
                        acc_idx = p_m1;
                    end
                    acc_mode  = M_INS;
                    acc_move  = 1'b1;
                    acc_rem   = CW'(c_ext - acc_idx);
                    acc_ptr   = AW'(c_ext - PW'(1));
                    acc_count = count_reg + CW'(1);
                end
            end
            FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_AT:
            begin
                if (count_reg == '0)
                begin
                    acc_status = ST_EMPTY;
                end
                else if ((req.func == FN_DEL_AT) && ((p_ext == '0) || (p_ext > c_ext)))
                begin
                    acc_status = ST_RANGE;
                end
                else
                begin
                    if (req.func == FN_DEL_FIRST)
                    begin
                        acc_idx = '0;
                    end
                    else if (req.func == FN_DEL_LAST)
                    begin
                        acc_idx = c_ext - PW'(1);
                    end
                    else
                    begin
                        acc_idx = p_m1;
                    end
                    acc_mode  = M_DEL;
                    acc_move  = 1'b1;
                    acc_rem   = CW'(c_ext - acc_idx);
                    acc_ptr   = AW'(acc_idx);
                    acc_count = count_reg - CW'(1);
                end
            end
            FN_READ_AT:
            begin
                if (count_reg == '0)
                begin
                    acc_status = ST_EMPTY;
                end
                else if ((p_ext == '0) || (p_ext > c_ext))
                begin
                    acc_status = ST_RANGE;
                end
                else
                begin
                    acc_mode = M_GET;
                    acc_move = 1'b1;
                    acc_rem  = CW'(1);
                    acc_ptr  = AW'(p_m1);
                end
            end
            default:
            begin
                acc_status = ST_OK;
            end
        endcase
    end

    // Sequencer: accept, stream entries through the RAM, then load the response.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        issued_next    = issued_reg;
        first_next     = first_reg;
        rsp_valid_next = rsp_valid_reg;
        mode_next      = mode_reg;
        rem_next       = rem_reg;
        ptr_next       = ptr_reg;
        pend_addr_next = pend_addr_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        rv_next        = rv_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;

        // The consumer takes a waiting response.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    count_next  = acc_count;
                    status_next = acc_status;
                    mode_next   = acc_mode;
                    rem_next    = acc_rem;
                    ptr_next    = acc_ptr;
                    idx_next    = AW'(acc_idx);
                    value_next  = DATA_WIDTH'(EXT_W'($signed(req.value)));
                    rv_next     = '0;
                    pend_next   = 1'b0;
                    issued_next = 1'b0;
                    state_next  = acc_move ? S_MOVE : S_DONE;
                end
            end
            S_MOVE:
            begin
                // Retire the read issued in the previous cycle.
                if (pend_reg)
                begin
                    unique case (mode_reg)
                        M_INS:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pend_addr_reg + AW'(1);
                        end
                        M_DEL:
                        begin
                            if (first_reg)
                            begin
                                rv_next = rd_word;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pend_addr_reg - AW'(1);
                            end
                        end
                        default:
                        begin
                            rv_next = rd_word;
                        end
                    endcase
                end

                // Issue the next read, or finish once the pipeline is empty.
                if (rem_reg != '0)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    first_next     = !issued_reg;
                    issued_next    = 1'b1;
                    rem_next       = rem_reg - CW'(1);
                    ptr_next       = (mode_reg == M_INS) ? ptr_reg - AW'(1)
                                                         : ptr_reg + AW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (mode_reg == M_INS)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = idx_reg;
                            ram_wdata = value_reg;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status     = status_reg;
                    rsp_next.read_value = rv_reg;
                    rsp_next.count      = COUNT_W'(count_reg);
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            issued_reg    <= 1'b0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            issued_reg    <= issued_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        rem_reg       <= rem_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        idx_reg       <= idx_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        rv_reg        <= rv_next;
        rsp_reg       <= rsp_next;
    end

endmodule

// ----- sv/ple_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
